### design/lob_pkg.sv
// Shared types and constants for the limit order book.
// Used by lob_best and limit_order_book; depends on nothing.
package lob_pkg;

    localparam int ORDER_SLOTS_DEF  = 1024;
    localparam int PRICE_LEVELS_DEF = 256;
    localparam int QTY_BITS_DEF     = 20;

    localparam int MODE_W      = 2;
    localparam int ID_IN_W     = 10;
    localparam int PRICE_IN_W  = 8;
    localparam int QTY_IN_W    = 20;
    localparam int STATUS_W    = 3;
    localparam int SEQ_W       = 32;
    localparam int SUM_W       = 31;
    localparam int SPREAD_W    = 9;
    localparam int PRICE_MAX_W = 12;
    localparam int GROUP_SIZE  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_ZERO_QTY   = 3'd1,
        STAT_DUP_ID     = 3'd2,
        STAT_UNKNOWN_ID = 3'd3,
        STAT_OVERFILL   = 3'd4
    } status_t;

    typedef struct packed {
        logic                   bid_valid;
        logic [PRICE_MAX_W-1:0] bid;
        logic                   ask_valid;
        logic [PRICE_MAX_W-1:0] ask;
    } best_t;

endpackage

### design/lob_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/lob_best.sv
// Two-step search for the best bid and best ask over the level occupancy bits.
// Depends on lob_pkg.
module lob_best #(
    parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [PRICE_LEVELS-1:0] bid_busy,
    input  logic [PRICE_LEVELS-1:0] ask_busy,
    output lob_pkg::best_t          best
);

    localparam int GS = lob_pkg::GROUP_SIZE;
    localparam int NG = PRICE_LEVELS / GS;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int LW = $clog2(GS);

    logic [NG-1:0] bid_grp;
    logic [NG-1:0] ask_grp;
    logic [GW-1:0] bid_g;
    logic [GW-1:0] ask_g;
    logic [GW-1:0] bid_g_reg;
    logic [GW-1:0] ask_g_reg;
    logic          bid_any_reg;
    logic          ask_any_reg;
    logic [GS-1:0] bid_slice;
    logic [GS-1:0] ask_slice;
    logic [LW-1:0] bid_l;
    logic [LW-1:0] ask_l;

    // First step: pick the group that holds the best level on each side.
    always_comb
    begin
        bid_g = '0;
        ask_g = '0;
        for (int g = 0; g < NG; g++)
        begin
            bid_grp[g] = |bid_busy[g*GS +: GS];
            ask_grp[g] = |ask_busy[g*GS +: GS];
        end
        for (int g = 0; g < NG; g++)
        begin
            if (bid_grp[g])
            begin
                bid_g = GW'(g);
            end
        end
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (ask_grp[g])
            begin
                ask_g = GW'(g);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_g_reg   <= '0;
            ask_g_reg   <= '0;
            bid_any_reg <= 1'b0;
            ask_any_reg <= 1'b0;
        end
        else if (start)
        begin
            bid_g_reg   <= bid_g;
            ask_g_reg   <= ask_g;
            bid_any_reg <= |bid_grp;
            ask_any_reg <= |ask_grp;
        end
    end

    // Second step: pick the level inside the chosen group.
    always_comb
    begin
        bid_slice = bid_busy[bid_g_reg*GS +: GS];
        ask_slice = ask_busy[ask_g_reg*GS +: GS];
        bid_l = '0;
        ask_l = '0;
        for (int i = 0; i < GS; i++)
        begin
            if (bid_slice[i])
            begin
                bid_l = LW'(i);
            end
        end
        for (int i = GS - 1; i >= 0; i--)
        begin
            if (ask_slice[i])
            begin
                ask_l = LW'(i);
            end
        end
        best.bid_valid = bid_any_reg;
        best.ask_valid = ask_any_reg;
        best.bid = bid_any_reg ? lob_pkg::PRICE_MAX_W'({bid_g_reg, bid_l}) : '0;
        best.ask = ask_any_reg ? lob_pkg::PRICE_MAX_W'({ask_g_reg, ask_l}) : '0;
    end

endmodule

### design/limit_order_book.sv
// Limit order book with a FIFO queue of orders at each price tick of each side.
// Depends on lob_pkg, lob_ram and lob_best.
//
// A word's result is registered when the output is free, after these steps: the
// slot and link reads issue at acceptance, then come the level read, the write
// back of slot, links and level, and the two steps of the best price search. The
// block takes the next word in the cycle after the result is registered, so it
// accepts no new word while one is in progress. A stalled output holds the block
// in its last step. After reset the block clears all ORDER_SLOTS entries (1024
// by default) of the order table before it accepts the first word.
module limit_order_book #(
    parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF,
    parameter int QTY_BITS     = lob_pkg::QTY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lob_pkg::MODE_W-1:0]          mode,
    input  logic [lob_pkg::ID_IN_W-1:0]         order_ref,
    input  logic                                side,
    input  logic [lob_pkg::PRICE_IN_W-1:0]      price_tick,
    input  logic [lob_pkg::QTY_IN_W-1:0]        quantity,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lob_pkg::STATUS_W-1:0]        status,
    output logic [lob_pkg::QTY_IN_W-1:0]        order_qty,
    output logic [lob_pkg::SEQ_W-1:0]           sequence_number,
    output logic                                bid_valid,
    output logic [lob_pkg::PRICE_IN_W-1:0]      top_bid,
    output logic                                ask_valid,
    output logic [lob_pkg::PRICE_IN_W-1:0]      top_ask,
    output logic signed [lob_pkg::SPREAD_W-1:0] spread_ticks,
    output logic [lob_pkg::SUM_W-1:0]           level_qty,
    output logic [lob_pkg::SUM_W-1:0]           bid_total,
    output logic [lob_pkg::SUM_W-1:0]           ask_total
);

    localparam int IW  = $clog2(ORDER_SLOTS);
    localparam int PW  = $clog2(PRICE_LEVELS);
    localparam int LVW = PW + 1;
    localparam int NLV = 2 * PRICE_LEVELS;
    localparam int QB  = QTY_BITS;
    localparam int SW  = lob_pkg::SUM_W;

    typedef struct packed {
        logic          live;
        logic          side;
        logic [PW-1:0] price;
        logic [QB-1:0] rem;
    } slot_info_t;

    typedef struct packed {
        logic [IW-1:0] head;
        logic [IW-1:0] tail;
        logic [SW-1:0] sum;
    } level_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                         state_reg;
    logic [IW-1:0]                  clr_idx_reg;
    lob_pkg::mode_t                 mode_reg;
    logic [IW-1:0]                  id_reg;
    logic                           side_reg;
    logic [PW-1:0]                  price_reg;
    logic [QB-1:0]                  qty_reg;
    logic [LVW-1:0]                 aff_reg;
    lob_pkg::status_t               status_reg;
    logic [QB-1:0]                  oqty_reg;
    logic [lob_pkg::SEQ_W-1:0]      seq_out_reg;
    logic [SW-1:0]                  lvl_qty_reg;
    logic [NLV-1:0]                 busy_reg;
    logic [SW-1:0]                  buy_depth_reg;
    logic [SW-1:0]                  sell_depth_reg;
    logic [lob_pkg::SEQ_W-1:0]      seq_reg;
    logic                           out_valid_reg;
    lob_pkg::status_t               status_out_reg;
    logic [lob_pkg::QTY_IN_W-1:0]   order_qty_reg;
    logic [lob_pkg::SEQ_W-1:0]      seq_num_reg;
    lob_pkg::best_t                 best_out_reg;
    logic signed [lob_pkg::SPREAD_W-1:0] spread_reg;
    logic [SW-1:0]                  level_qty_reg;
    logic [SW-1:0]                  bid_total_reg;
    logic [SW-1:0]                  ask_total_reg;

    logic          accept;
    logic [IW-1:0] in_id;

    logic          slot_we;
    logic [IW-1:0] slot_waddr;
    slot_info_t    slot_wdata;
    slot_info_t    slot_rd;
    logic          prev_we;
    logic [IW-1:0] prev_waddr;
    logic [IW-1:0] prev_wdata;
    logic [IW-1:0] prev_rd;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [IW-1:0] next_wdata;
    logic [IW-1:0] next_rd;
    logic          lvl_we;
    level_t        lvl_wdata;
    level_t        lvl_rd;
    logic          lvl_re;
    logic [LVW-1:0] aff_c;

    logic             lbusy;
    logic             is_head;
    logic             is_tail;
    logic             unlink;
    logic             new_busy;
    logic [SW-1:0]    new_sum;
    logic [QB-1:0]    new_rem;
    logic [SW-1:0]    sub_q;
    logic [SW-1:0]    add_q;
    logic             seq_inc;
    lob_pkg::status_t status_c;
    logic [QB-1:0]    oqty_c;
    logic [lob_pkg::SEQ_W-1:0] seq_c;

    lob_pkg::best_t   best;
    logic             out_load;
    logic signed [lob_pkg::PRICE_MAX_W:0] diff;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_id    = IW'(order_ref);

    // Affected level: the order's own level for a live cancel or fill.
    always_comb
    begin
        if ((mode_reg == lob_pkg::MODE_CANCEL || mode_reg == lob_pkg::MODE_FILL)
            && slot_rd.live)
        begin
            aff_c = {slot_rd.side, slot_rd.price};
        end
        else
        begin
            aff_c = {side_reg, price_reg};
        end
    end
    assign lvl_re = (state_reg == S_RD1);

    // Operation decode and write back.
    always_comb
    begin
        lbusy      = busy_reg[aff_reg];
        is_head    = (lvl_rd.head == id_reg);
        is_tail    = (lvl_rd.tail == id_reg);
        unlink     = 1'b0;
        new_busy   = lbusy;
        new_sum    = lvl_rd.sum;
        new_rem    = slot_rd.rem - qty_reg;
        sub_q      = '0;
        add_q      = '0;
        seq_inc    = 1'b0;
        status_c   = lob_pkg::STAT_OK;
        oqty_c     = '0;
        seq_c      = '0;
        slot_we    = 1'b0;
        slot_waddr = id_reg;
        slot_wdata = slot_rd;
        prev_we    = 1'b0;
        prev_waddr = id_reg;
        prev_wdata = lvl_rd.tail;
        next_we    = 1'b0;
        next_waddr = lvl_rd.tail;
        next_wdata = id_reg;
        lvl_we     = 1'b0;
        lvl_wdata  = lvl_rd;

        if (state_reg == S_CLEAR)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_idx_reg;
            slot_wdata = '0;
        end
        else if (state_reg == S_RD2)
        begin
            case (mode_reg)
                lob_pkg::MODE_ADD:
                begin
                    if (qty_reg == '0)
                    begin
                        status_c = lob_pkg::STAT_ZERO_QTY;
                    end
                    else if (slot_rd.live)
                    begin
                        status_c = lob_pkg::STAT_DUP_ID;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = '{live: 1'b1, side: side_reg, price: price_reg,
                                       rem: qty_reg};
                        seq_c      = seq_reg;
                        seq_inc    = 1'b1;
                        add_q      = SW'(qty_reg);
                        oqty_c     = qty_reg;
                        lvl_we     = 1'b1;
                        new_busy   = 1'b1;
                        if (lbusy)
                        begin
                            prev_we   = 1'b1;
                            next_we   = 1'b1;
                            new_sum   = lvl_rd.sum + SW'(qty_reg);
                            lvl_wdata = '{head: lvl_rd.head, tail: id_reg, sum: new_sum};
                        end
                        else
                        begin
                            new_sum   = SW'(qty_reg);
                            lvl_wdata = '{head: id_reg, tail: id_reg, sum: new_sum};
                        end
                    end
                end
                lob_pkg::MODE_CANCEL:
                begin
                    if (!slot_rd.live)
                    begin
                        status_c = lob_pkg::STAT_UNKNOWN_ID;
                    end
                    else
                    begin
                        sub_q      = SW'(slot_rd.rem);
                        oqty_c     = slot_rd.rem;
                        unlink     = 1'b1;
                        slot_we    = 1'b1;
                        slot_wdata.live = 1'b0;
                        new_sum    = lvl_rd.sum - SW'(slot_rd.rem);
                    end
                end
                lob_pkg::MODE_FILL:
                begin
                    if (!slot_rd.live)
                    begin
                        status_c = lob_pkg::STAT_UNKNOWN_ID;
                    end
                    else if (qty_reg == '0)
                    begin
                        status_c = lob_pkg::STAT_ZERO_QTY;
                    end
                    else if (qty_reg > slot_rd.rem)
                    begin
                        status_c = lob_pkg::STAT_OVERFILL;
                    end
                    else
                    begin
                        sub_q      = SW'(qty_reg);
                        oqty_c     = new_rem;
                        unlink     = (new_rem == '0);
                        slot_we    = 1'b1;
                        slot_wdata.live = (new_rem != '0);
                        slot_wdata.rem  = new_rem;
                        new_sum    = lvl_rd.sum - SW'(qty_reg);
                    end
                end
                default:
                begin
                end
            endcase

            if (sub_q != '0 || unlink)
            begin
                lvl_we    = 1'b1;
                lvl_wdata = '{head: lvl_rd.head, tail: lvl_rd.tail, sum: new_sum};
            end
            if (unlink)
            begin
                if (is_head && is_tail)
                begin
                    new_busy = 1'b0;
                end
                else
                begin
                    lvl_wdata.head = is_head ? next_rd : lvl_rd.head;
                    lvl_wdata.tail = is_tail ? prev_rd : lvl_rd.tail;
                    next_we    = !is_head;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    prev_we    = !is_tail;
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                end
            end
        end
    end

    lob_ram #(.WIDTH($bits(slot_info_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (accept),
        .raddr (in_id),
        .rdata (slot_rd)
    );

    lob_ram #(.WIDTH(IW), .DEPTH(ORDER_SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (accept),
        .raddr (in_id),
        .rdata (prev_rd)
    );

    lob_ram #(.WIDTH(IW), .DEPTH(ORDER_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (accept),
        .raddr (in_id),
        .rdata (next_rd)
    );

    lob_ram #(.WIDTH($bits(level_t)), .DEPTH(NLV)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (aff_reg),
        .wdata (lvl_wdata),
        .re    (lvl_re),
        .raddr (aff_c),
        .rdata (lvl_rd)
    );

    lob_best #(.PRICE_LEVELS(PRICE_LEVELS)) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SCAN),
        .bid_busy (busy_reg[PRICE_LEVELS-1:0]),
        .ask_busy (busy_reg[NLV-1:PRICE_LEVELS]),
        .best     (best)
    );

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign diff = $signed({1'b0, best.ask}) - $signed({1'b0, best.bid});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            busy_reg       <= '0;
            buy_depth_reg  <= '0;
            sell_depth_reg <= '0;
            seq_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IW'(ORDER_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg  <= lob_pkg::mode_t'(mode);
                        id_reg    <= in_id;
                        side_reg  <= side;
                        price_reg <= PW'(price_tick);
                        qty_reg   <= QB'(quantity);
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    aff_reg   <= aff_c;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    busy_reg[aff_reg] <= new_busy;
                    status_reg  <= status_c;
                    oqty_reg    <= oqty_c;
                    seq_out_reg <= seq_c;
                    lvl_qty_reg <= new_busy ? new_sum : '0;
                    if (seq_inc)
                    begin
                        seq_reg <= seq_reg + 1'b1;
                    end
                    if (aff_reg[PW])
                    begin
                        sell_depth_reg <= sell_depth_reg + add_q - sub_q;
                    end
                    else
                    begin
                        buy_depth_reg <= buy_depth_reg + add_q - sub_q;
                    end
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_out_reg <= status_reg;
                        order_qty_reg  <= lob_pkg::QTY_IN_W'(oqty_reg);
                        seq_num_reg    <= seq_out_reg;
                        best_out_reg   <= best;
                        spread_reg     <= (best.bid_valid && best.ask_valid)
                                          ? lob_pkg::SPREAD_W'(diff) : '0;
                        level_qty_reg  <= lvl_qty_reg;
                        bid_total_reg  <= buy_depth_reg;
                        ask_total_reg  <= sell_depth_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign order_qty       = order_qty_reg;
    assign sequence_number = seq_num_reg;
    assign bid_valid       = best_out_reg.bid_valid;
    assign top_bid         = lob_pkg::PRICE_IN_W'(best_out_reg.bid);
    assign ask_valid       = best_out_reg.ask_valid;
    assign top_ask         = lob_pkg::PRICE_IN_W'(best_out_reg.ask);
    assign spread_ticks    = spread_reg;
    assign level_qty       = level_qty_reg;
    assign bid_total       = bid_total_reg;
    assign ask_total       = ask_total_reg;

    a_busy_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_RD2) |=> $stable(busy_reg))
        else $error("Level occupancy changed outside the write-back cycle.");

    a_seq_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(seq_reg) |-> (seq_reg == $past(seq_reg) + 1'b1))
        else $error("Sequence counter moved by other than one.");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("Result word raised outside the output step.");

    a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(slot_we || prev_we || next_we || lvl_we))
        else $error("Memory written while no word is in progress.");

endmodule

### tb/sv/limit_order_book_tb.sv
// Self-checking testbench for limit_order_book: directed and random order traffic
// checked against an in-bench behavioral book. Depends on lob_pkg and limit_order_book.
module limit_order_book_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SLOTS       = 1024;
    localparam int  TICKS       = 256;
    localparam int  QTY_MAX     = 20'hFFFFF;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 20;

    typedef struct {
        lob_pkg::status_t   st;
        logic [19:0]        oqty;
        logic [31:0]        seq;
        logic               bv;
        logic [7:0]         bb;
        logic               av;
        logic [7:0]         ba;
        logic signed [8:0]  spread;
        logic [30:0]        lq;
        logic [30:0]        bt;
        logic [30:0]        at;
    } book_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = '0;
    logic [9:0]  order_ref = '0;
    logic        side = 1'b0;
    logic [7:0]  price_tick = '0;
    logic [19:0] quantity = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [19:0] order_qty;
    logic [31:0] sequence_number;
    logic        bid_valid;
    logic [7:0]  top_bid;
    logic        ask_valid;
    logic [7:0]  top_ask;
    logic signed [8:0] spread_ticks;
    logic [30:0] level_qty;
    logic [30:0] bid_total;
    logic [30:0] ask_total;

    // Behavioral copy of the book.
    bit          live[SLOTS];
    bit          o_side[SLOTS];
    logic [7:0]  o_price[SLOTS];
    logic [19:0] o_rem[SLOTS];
    logic [9:0]  o_prev[SLOTS];
    logic [9:0]  o_next[SLOTS];
    logic [9:0]  lv_head[2*TICKS];
    logic [9:0]  lv_tail[2*TICKS];
    longint      lv_sum[2*TICKS];
    bit          lv_busy[2*TICKS];
    longint      buy_sum;
    longint      sell_sum;
    logic [31:0] next_seq = '0;

    book_result_t pending_results[$];
    int errors;
    int words_sent;
    int results_seen;
    int cycles;
    int send_idle;
    int recv_idle;
    int hold_left;

    limit_order_book dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .order_ref(order_ref), .side(side),
        .price_tick(price_tick), .quantity(quantity),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .order_qty(order_qty), .sequence_number(sequence_number),
        .bid_valid(bid_valid), .top_bid(top_bid),
        .ask_valid(ask_valid), .top_ask(top_ask),
        .spread_ticks(spread_ticks), .level_qty(level_qty),
        .bid_total(bid_total), .ask_total(ask_total)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [30:0] sat31(longint v);
        return (v > 64'h7FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
    endfunction

    function automatic void unlink_order(int id);
        int lv;
        bit at_head;
        bit at_tail;
        lv = int'({o_side[id], o_price[id]});
        at_head = (lv_head[lv] == id);
        at_tail = (lv_tail[lv] == id);
        if (at_head && at_tail)
            lv_busy[lv] = 1'b0;
        else
        begin
            if (at_head) lv_head[lv] = o_next[id];
            else o_next[o_prev[id]] = o_next[id];
            if (at_tail) lv_tail[lv] = o_prev[id];
            else o_prev[o_next[id]] = o_prev[id];
        end
        live[id] = 1'b0;
    endfunction

    function automatic book_result_t apply_order(lob_pkg::mode_t m, int id, bit s, int p,
                                                 int q);
        book_result_t r;
        int lv;
        int bb;
        int ba;
        longint rem;
        r = '{st: lob_pkg::STAT_OK, oqty: '0, seq: '0, bv: 1'b0, bb: '0, av: 1'b0,
              ba: '0, spread: '0, lq: '0, bt: '0, at: '0};
        if ((m == lob_pkg::MODE_CANCEL || m == lob_pkg::MODE_FILL) && live[id])
            lv = int'({o_side[id], o_price[id]});
        else
            lv = int'({s, p[7:0]});
        case (m)
            lob_pkg::MODE_ADD:
                if (q == 0) r.st = lob_pkg::STAT_ZERO_QTY;
                else if (live[id]) r.st = lob_pkg::STAT_DUP_ID;
                else
                begin
                    r.seq = next_seq;
                    next_seq++;
                    live[id] = 1'b1;
                    o_side[id] = s;
                    o_price[id] = 8'(p);
                    o_rem[id] = 20'(q);
                    if (lv_busy[lv])
                    begin
                        o_prev[id] = lv_tail[lv];
                        o_next[lv_tail[lv]] = 10'(id);
                        lv_tail[lv] = 10'(id);
                        lv_sum[lv] += q;
                    end
                    else
                    begin
                        lv_busy[lv] = 1'b1;
                        lv_head[lv] = 10'(id);
                        lv_tail[lv] = 10'(id);
                        o_prev[id] = 10'(id);
                        lv_sum[lv] = q;
                    end
                    o_next[id] = 10'(id);
                    if (s) sell_sum += q; else buy_sum += q;
                    r.oqty = 20'(q);
                end
            lob_pkg::MODE_CANCEL:
                if (!live[id]) r.st = lob_pkg::STAT_UNKNOWN_ID;
                else
                begin
                    rem = o_rem[id];
                    lv_sum[lv] -= rem;
                    if (o_side[id]) sell_sum -= rem; else buy_sum -= rem;
                    unlink_order(id);
                    r.oqty = 20'(rem);
                end
            lob_pkg::MODE_FILL:
                if (!live[id]) r.st = lob_pkg::STAT_UNKNOWN_ID;
                else if (q == 0) r.st = lob_pkg::STAT_ZERO_QTY;
                else if (q > o_rem[id]) r.st = lob_pkg::STAT_OVERFILL;
                else
                begin
                    lv_sum[lv] -= q;
                    if (o_side[id]) sell_sum -= q; else buy_sum -= q;
                    o_rem[id] = 20'(o_rem[id] - q);
                    r.oqty = o_rem[id];
                    if (o_rem[id] == 0) unlink_order(id);
                end
            default: ;
        endcase
        bb = -1;
        ba = -1;
        for (int i = TICKS - 1; i >= 0; i--)
            if (bb < 0 && lv_busy[i]) bb = i;
        for (int i = 0; i < TICKS; i++)
            if (ba < 0 && lv_busy[TICKS + i]) ba = i;
        r.bv = (bb >= 0);
        r.bb = (bb >= 0) ? bb[7:0] : 8'd0;
        r.av = (ba >= 0);
        r.ba = (ba >= 0) ? ba[7:0] : 8'd0;
        if (bb >= 0 && ba >= 0) r.spread = 9'(ba - bb);
        r.lq = lv_busy[lv] ? sat31(lv_sum[lv]) : 31'd0;
        r.bt = sat31(buy_sum);
        r.at = sat31(sell_sum);
        return r;
    endfunction

    task automatic send_word(lob_pkg::mode_t m, int id, bit s, int p, int q);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        order_ref = 10'(id);
        side = s;
        price_tick = 8'(p);
        quantity = 20'(q);
        do @(posedge clk); while (!in_ready);
        pending_results.insert(pending_results.size(), apply_order(m, id, s, p, q));
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle);
    end

    function automatic void check_field(string name, longint exp, longint got);
        if (exp != got)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        book_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.st, status);
                check_field("order_qty", e.oqty, order_qty);
                check_field("sequence_number", e.seq, sequence_number);
                check_field("bid_valid", e.bv, bid_valid);
                check_field("top_bid", e.bb, top_bid);
                check_field("ask_valid", e.av, ask_valid);
                check_field("top_ask", e.ba, top_ask);
                check_field("spread_ticks", e.spread, spread_ticks);
                check_field("level_qty", e.lq, level_qty);
                check_field("bid_total", e.bt, bid_total);
                check_field("ask_total", e.at, ask_total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("limit_order_book_tb failed");
            $finish;
        end
    end

    function automatic int pick_order_id();
        int id;
        id = $urandom_range(SLOTS - 1);
        for (int t = 0; t < 32 && !live[id]; t++)
            id = $urandom_range(SLOTS - 1);
        return id;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 0;
        if (r < 6) return QTY_MAX;
        if (r < 16) return $urandom_range(QTY_MAX);
        return $urandom_range(1, 1000);
    endfunction

    task automatic test_directed();
        send_word(lob_pkg::MODE_CANCEL, 5, 1'b0, 0, 0);
        send_word(lob_pkg::MODE_FILL, 5, 1'b1, 255, 10);
        send_word(lob_pkg::MODE_ADD, 0, 1'b0, 0, QTY_MAX);
        send_word(lob_pkg::MODE_ADD, 1023, 1'b1, 255, 1);
        send_word(lob_pkg::MODE_ADD, 7, 1'b0, 10, 0);
        send_word(lob_pkg::MODE_ADD, 0, 1'b1, 40, 5);
        send_word(lob_pkg::MODE_ADD, 10, 1'b0, 200, 100);
        send_word(lob_pkg::MODE_ADD, 11, 1'b1, 10, 50);
        send_word(lob_pkg::MODE_ADD, 12, 1'b1, 10, 60);
        send_word(lob_pkg::MODE_ADD, 13, 1'b1, 10, 70);
        send_word(lob_pkg::MODE_ADD, 14, 1'b1, 10, 80);
        send_word(lob_pkg::MODE_FILL, 12, 1'b0, 0, 0);
        send_word(lob_pkg::MODE_FILL, 12, 1'b0, 0, 61);
        send_word(lob_pkg::MODE_FILL, 12, 1'b0, 0, 20);
        send_word(lob_pkg::MODE_CANCEL, 13, 1'b0, 0, 0);
        send_word(lob_pkg::MODE_FILL, 11, 1'b0, 0, 50);
        send_word(lob_pkg::MODE_CANCEL, 14, 1'b0, 0, 0);
        send_word(lob_pkg::MODE_FILL, 12, 1'b0, 0, 40);
        send_word(lob_pkg::MODE_NONE, 10, 1'b1, 255, QTY_MAX);
        send_word(lob_pkg::MODE_CANCEL, 10, 1'b0, 0, 0);
        send_word(lob_pkg::MODE_FILL, 0, 1'b0, 0, QTY_MAX);
        send_word(lob_pkg::MODE_CANCEL, 1023, 1'b0, 0, 0);
        wait_drained();
    endtask

    task automatic test_random_traffic(int count);
        int r;
        int id;
        int q;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_word(lob_pkg::MODE_ADD, $urandom_range(SLOTS - 1),
                          1'($urandom_range(1)),
                          ($urandom_range(99) < 80) ? 120 + $urandom_range(15)
                                                    : $urandom_range(TICKS - 1),
                          pick_size());
            else if (r < 65)
                send_word(lob_pkg::MODE_CANCEL, pick_order_id(), 1'($urandom_range(1)),
                          $urandom_range(TICKS - 1), $urandom_range(QTY_MAX));
            else if (r < 95)
            begin
                id = pick_order_id();
                q = live[id] ? o_rem[id] : 1;
                r = $urandom_range(99);
                if (r < 40 && q > 1) q = $urandom_range(1, q - 1);
                else if (r < 70) q = q;
                else if (r < 80 && q < QTY_MAX) q = q + 1;
                else if (r < 90) q = 0;
                else q = $urandom_range(QTY_MAX);
                send_word(lob_pkg::MODE_FILL, id, 1'($urandom_range(1)),
                          $urandom_range(TICKS - 1), q);
            end
            else
                send_word(lob_pkg::mode_t'($urandom_range(3)), $urandom_range(SLOTS - 1),
                          1'($urandom_range(1)), $urandom_range(TICKS - 1),
                          $urandom_range(QTY_MAX));
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        send_idle = 0;
        hold_left = 400;
        test_random_traffic(60);
    endtask

    initial
    begin
        send_idle = 29;
        recv_idle = 65;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_traffic(480);
        send_idle = 65;
        recv_idle = 29;
        test_random_traffic(480);
        send_idle = 0;
        recv_idle = 0;
        test_random_traffic(480);
        test_output_backpressure();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d words of add, cancel, fill and unused mode traffic;", words_sent);
        $display("checked %0d result words under varied idling and a long output stall.",
                 results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("limit_order_book_tb passed");
        else
            $display("limit_order_book_tb failed");
        $finish;
    end

endmodule
